// ----- rtl/image_map_region_hit_test_top_macros.svh -----
// Assertion helpers used by the hit-test back stage.
`ifndef IMAGE_MAP_REGION_HIT_TEST_TOP_MACROS_SVH
`define IMAGE_MAP_REGION_HIT_TEST_TOP_MACROS_SVH

// Clocked check, off while reset is held.
`define IMRH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition now implies a consequence in the next cycle.
`define IMRH_ASSERT_NEXT(label, pre, post, msg) \
  `IMRH_ASSERT(label, (pre) |=> (post), msg)

`endif

// ----- rtl/imrh_pkg.sv -----
`timescale 1ns / 1ps

package imrh_pkg;

  localparam int unsigned COORD_BITS       = 16;
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned QDEPTH           = 4;

  localparam logic [15:0] COORD_MASK =
    (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);

  typedef enum logic [2:0] {
    OP_RECT   = 3'd0,
    OP_CIRCLE = 3'd1,
    OP_POLY   = 3'd2,
    OP_POINT  = 3'd3,
    OP_BEGIN  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_POLY   = 2'd2,
    KIND_POINT  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_CLICK_X = 1'b0,
    REG_CLICK_Y = 1'b1
  } reg_e;

  typedef logic [15:0]        coord_t;
  typedef logic signed [16:0] rel_t;
  typedef logic signed [33:0] prod_t;
  typedef logic [32:0]        dist_t;

  typedef struct packed {
    logic       clear;
    kind_e      kind;
    logic [7:0] rid;
    logic       last;
    logic       start;
    logic       status;
    logic       rect_hit;
    logic       vtx_hit;
    logic       edge1_en;
    logic       edge2_en;
  } ctrl_t;

  // Operand pairs for the four multipliers. Edge: a = y2*x in slot 0/2, b = x2*y in 1/3.
  typedef struct packed {
    ctrl_t      ctrl;
    rel_t [3:0] opa;
    rel_t [3:0] opb;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic signed [2:0] val;
  } edge_t;

  function automatic rel_t rel(coord_t a, coord_t b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // Half-crossing contribution of edge (x2,y2)->(x,y), relative to the click.
  function automatic edge_t edge_cross(rel_t x2, rel_t y2, rel_t x, rel_t y,
                                       prod_t a, prod_t b);
    edge_t             r;
    logic signed [2:0] sgn;
    logic signed [2:0] sgn2;
    r.hit = 1'b0;
    r.val = 3'sd0;
    sgn   = (y > 0) ? 3'sd1 : -3'sd1;
    sgn2  = (y > 0) ? 3'sd2 : -3'sd2;
    if (y == 0) begin
      if (x == 0) begin
        r.hit = 1'b1;
      end else if (x > 0) begin
        if (y2 == 0) r.hit = !(x2 > 0);
        else         r.val = (y2 < 0) ? 3'sd1 : -3'sd1;
      end else if (y2 == 0) begin
        r.hit = !(x2 < 0);
      end
    end else if (y2 == 0) begin
      if (!(x2 < 0)) r.val = sgn;
    end else if ((y > 0) != (y2 > 0)) begin
      if (x >= 0 && x2 > 0) begin
        r.val = sgn2;
      end else if (!(x < 0 && x2 <= 0)) begin
        if (a == b)                   r.hit = 1'b1;
        else if ((y > 0) != (a > b))  r.val = sgn2;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/imrh_fifo.sv -----
`timescale 1ns / 1ps

module imrh_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  imrh_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output imrh_pkg::cmd_t data_o
);
  import imrh_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- rtl/imrh_front.sv -----
`timescale 1ns / 1ps

module imrh_front #(
  parameter int unsigned MAX_VERTICES = imrh_pkg::MAX_VERTICES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     op_i,
  input  logic [7:0]     rid_i,
  input  logic [15:0]    x_i,
  input  logic [15:0]    y_i,
  input  logic           last_i,
  input  logic           q_full_i,
  output logic           push_o,
  output imrh_pkg::cmd_t cmd_o
);
  import imrh_pkg::*;

  localparam int unsigned      CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  coord_t           click_x_q, click_y_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_eff;
  kind_e            kind_q, kind_d;
  coord_t           first_x_q, first_x_d, first_y_q, first_y_d;
  coord_t           prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  coord_t           cx, cy;
  logic             accept, start, push;
  cmd_t             cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && push;
  assign cmd_o      = cmd;

  always_comb begin
    cx        = x_i & COORD_MASK;
    cy        = y_i & COORD_MASK;
    cnt_eff   = (cnt_q != '0 && op_i[1:0] != kind_q) ? '0 : cnt_q;
    start     = (cnt_eff == '0);
    kind_d    = kind_q;
    cnt_d     = cnt_eff;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    push      = 1'b0;
    cmd       = '0;
    cmd.ctrl.kind  = kind_e'(op_i[1:0]);
    cmd.ctrl.rid   = rid_i;
    cmd.ctrl.last  = last_i;
    cmd.ctrl.start = start;
    unique case (op_e'(op_i))
      OP_RECT, OP_CIRCLE: begin
        push = 1'b1;
        if (start) kind_d = kind_e'(op_i[1:0]);
        if (cnt_eff == '0) begin
          first_x_d = cx;
          first_y_d = cy;
          cnt_d     = CNT_W'(1);
        end else if (cnt_eff == CNT_W'(1)) begin
          prev_x_d = cx;
          prev_y_d = cy;
          cnt_d    = CNT_W'(2);
        end
        cmd.ctrl.status   = (cnt_d < CNT_W'(2));
        cmd.ctrl.rect_hit = first_x_d <= click_x_q && prev_x_d >= click_x_q &&
                            first_y_d <= click_y_q && prev_y_d >= click_y_q;
        cmd.opa[0] = rel(first_x_d, prev_x_d);
        cmd.opa[1] = rel(first_y_d, prev_y_d);
        cmd.opa[2] = rel(first_x_d, click_x_q);
        cmd.opa[3] = rel(first_y_d, click_y_q);
        cmd.opb    = cmd.opa;
      end
      OP_POLY: begin
        push   = 1'b1;
        if (start) kind_d = KIND_POLY;
        if (cnt_eff == '0) begin
          first_x_d = cx;
          first_y_d = cy;
          prev_x_d  = cx;
          prev_y_d  = cy;
          cmd.ctrl.vtx_hit = (cx == click_x_q) && (cy == click_y_q);
          cnt_d     = CNT_W'(1);
        end else if (cnt_eff < CNT_MAX) begin
          cmd.ctrl.edge1_en = 1'b1;
          cmd.opa[0] = rel(prev_y_q, click_y_q);
          cmd.opb[0] = rel(cx, click_x_q);
          cmd.opa[1] = rel(prev_x_q, click_x_q);
          cmd.opb[1] = rel(cy, click_y_q);
          prev_x_d   = cx;
          prev_y_d   = cy;
          cnt_d      = cnt_eff + CNT_W'(1);
        end
        // closing edge, last vertex back to the first
        cmd.ctrl.edge2_en = last_i;
        cmd.opa[2] = rel(prev_y_d, click_y_q);
        cmd.opb[2] = rel(first_x_d, click_x_q);
        cmd.opa[3] = rel(prev_x_d, click_x_q);
        cmd.opb[3] = rel(first_y_d, click_y_q);
      end
      OP_POINT: begin
        push   = 1'b1;
        if (start) kind_d = KIND_POINT;
        cmd.opa[0] = rel(cx, click_x_q);
        cmd.opa[1] = rel(cy, click_y_q);
        cmd.opb    = cmd.opa;
        cnt_d      = CNT_W'(1);
      end
      OP_BEGIN: begin
        push = 1'b1;
        cmd.ctrl.clear = 1'b1;
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    if (push && !cmd.ctrl.clear && last_i) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_x_q <= '0;
      click_y_q <= '0;
      cnt_q     <= '0;
      kind_q    <= KIND_RECT;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_CLICK_X: click_x_q <= cfg_wdata_i;
          REG_CLICK_Y: click_y_q <= cfg_wdata_i;
        endcase
      end
      if (accept) begin
        cnt_q     <= cnt_d;
        kind_q    <= kind_d;
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        prev_x_q  <= prev_x_d;
        prev_y_q  <= prev_y_d;
      end
    end
  end

endmodule

// ----- rtl/imrh_back.sv -----
`timescale 1ns / 1ps
`include "image_map_region_hit_test_top_macros.svh"

module imrh_back #(
  parameter int unsigned MAX_VERTICES = imrh_pkg::MAX_VERTICES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  imrh_pkg::cmd_t q_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [55:0]    out_data_o,
  output logic [1:0]     out_kind_o
);
  import imrh_pkg::*;

  localparam int unsigned SUM_W = $clog2(MAX_VERTICES) + 3;

  // multiply stage
  logic  m_valid_q;
  ctrl_t m_ctrl_q;
  rel_t  m_opa_q [4];
  rel_t  m_opb_q [4];
  prod_t m_prod_q [4];
  prod_t prod_d [4];

  // region and map state
  logic signed [SUM_W-1:0] sum_q, sum_d, sum_base;
  logic                    edge_q, edge_d, edge_base;
  logic                    found_q, found_d;
  dist_t                   min_q, min_d;
  logic [7:0]              best_q, best_d;

  logic        out_valid_q;
  logic [55:0] out_data_q;
  kind_e       out_kind_q;

  edge_t e1, e2;
  dist_t sq01, sq23;
  logic  hit, emits, leave, pop;

  assign emits       = m_ctrl_q.last && !m_ctrl_q.clear;
  assign leave       = m_valid_q && (!emits || !out_valid_q || out_ready_i);
  assign pop         = q_valid_i && (!m_valid_q || leave);
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = $signed(q_cmd_i.opa[i]) * $signed(q_cmd_i.opb[i]);
    end
  end

  always_comb begin
    sq01 = {1'b0, m_prod_q[0][31:0]} + {1'b0, m_prod_q[1][31:0]};
    sq23 = {1'b0, m_prod_q[2][31:0]} + {1'b0, m_prod_q[3][31:0]};
    e1 = m_ctrl_q.edge1_en ?
         edge_cross(m_opa_q[1], m_opa_q[0], m_opb_q[0], m_opb_q[1], m_prod_q[0], m_prod_q[1]) :
         '0;
    e2 = m_ctrl_q.edge2_en ?
         edge_cross(m_opa_q[3], m_opa_q[2], m_opb_q[2], m_opb_q[3], m_prod_q[2], m_prod_q[3]) :
         '0;
    sum_base  = m_ctrl_q.start ? '0 : sum_q;
    edge_base = m_ctrl_q.start ? 1'b0 : edge_q;
    sum_d   = sum_q;
    edge_d  = edge_q;
    found_d = found_q;
    min_d   = min_q;
    best_d  = best_q;
    hit     = 1'b0;
    if (m_ctrl_q.clear) begin
      sum_d   = '0;
      edge_d  = 1'b0;
      found_d = 1'b0;
      min_d   = '0;
      best_d  = '0;
    end else begin
      sum_d  = sum_base + SUM_W'(e1.val) + SUM_W'(e2.val);
      edge_d = edge_base | m_ctrl_q.vtx_hit | e1.hit | e2.hit;
      unique case (m_ctrl_q.kind)
        KIND_RECT:   hit = !m_ctrl_q.status && m_ctrl_q.rect_hit;
        KIND_CIRCLE: hit = !m_ctrl_q.status && (sq23 <= sq01);
        KIND_POLY:   hit = edge_d || (sum_d != '0);
        KIND_POINT: begin
          if (!found_q || sq01 < min_q) begin
            found_d = 1'b1;
            min_d   = sq01;
            best_d  = m_ctrl_q.rid;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      sum_q       <= '0;
      edge_q      <= 1'b0;
      found_q     <= 1'b0;
      min_q       <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_RECT;
    end else begin
      if (pop)        m_valid_q <= 1'b1;
      else if (leave) m_valid_q <= 1'b0;
      if (leave) begin
        sum_q   <= sum_d;
        edge_q  <= edge_d;
        found_q <= found_d;
        min_q   <= min_d;
        best_q  <= best_d;
      end
      if (leave && emits) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= m_ctrl_q.kind;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_ctrl_q <= q_cmd_i.ctrl;
      for (int i = 0; i < 4; i++) begin
        m_opa_q[i]  <= q_cmd_i.opa[i];
        m_opb_q[i]  <= q_cmd_i.opb[i];
        m_prod_q[i] <= prod_d[i];
      end
    end
    if (leave && emits) begin
      out_data_q <= {4'b0, min_d, best_d, found_d, m_ctrl_q.status, hit, m_ctrl_q.rid};
    end
  end

  `IMRH_ASSERT(a_empty_nearest_zero, !found_q |-> (min_q == '0 && best_q == '0), "nearest state set without a point")
  `IMRH_ASSERT(a_status_no_hit, (out_valid_q && out_data_q[9]) |-> !out_data_q[8], "hit reported with short region")
  `IMRH_ASSERT(a_point_no_hit, (out_valid_q && out_kind_q == KIND_POINT) |-> !out_data_q[8], "point region reported a hit")
  `IMRH_ASSERT_NEXT(a_clear_drops_nearest, leave && m_ctrl_q.clear, !found_q, "begin map did not clear nearest")

endmodule

// ----- rtl/image_map_region_hit_test_top.sv -----
`timescale 1ns / 1ps
// A region's result passes the queue, the multiply-stage registers and the output register.
// One item per cycle unless the output stalls; each item uses the four multipliers once.
// A 4-entry queue between front and back absorbs output stalls before tready drops.
// Reset (rst_ni low, async): click registers, region tracking, nearest-point state,
// queue and all valid flags clear; no clearing pass is needed.
module image_map_region_hit_test_top #(
  parameter int unsigned MAX_VERTICES = imrh_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // region_id, coord_x, coord_y
  input  logic [2:0]  s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_region, hit, status, nearest_valid,
                                      // nearest_region, nearest_dist, zero pad
  output logic [1:0]  m_axis_tuser    // region_kind
);
  import imrh_pkg::*;

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, pop_cmd;

  imrh_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .rid_i       (s_axis_tdata[7:0]),
    .x_i         (s_axis_tdata[23:8]),
    .y_i         (s_axis_tdata[39:24]),
    .last_i      (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  imrh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (pop_cmd)
  );

  imrh_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_cmd_i     (pop_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

endmodule

// ----- sim/image_map_region_hit_test_top_tb.sv -----
`timescale 1ns / 1ps

module image_map_region_hit_test_top_tb;
  import imrh_pkg::*;

  localparam int ON_EDGE      = 3;
  localparam int COORD_MAX    = 65535;
  localparam int OP_LAST_CODE = 7;
  localparam int MAX_VTX      = MAX_VERTICES_DEF;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 8;

  typedef struct {
    logic [2:0] op;
    logic [7:0] rid;
    coord_t     x;
    coord_t     y;
    logic       last;
  } coord_item_t;

  typedef struct {
    logic [7:0]  region;
    kind_e       kind;
    logic        hit;
    logic        status;
    logic        nvalid;
    logic [7:0]  nregion;
    logic [32:0] ndist;
  } region_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_CLICK_X;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  image_map_region_hit_test_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  coord_item_t    coord_items[$];
  region_result_t due_results[$];
  int             fails = 0;

  // predictor state
  coord_t            click_x = '0;
  coord_t            click_y = '0;
  int unsigned       vtx_count = 0;
  coord_t            first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
  int                cross_total = 0;
  bit                on_edge = 1'b0;
  bit                near_seen = 1'b0;
  longint unsigned   near_dist = 0;
  logic [7:0]        near_region = '0;
  logic [2:0]        open_op = OP_RECT;

  function automatic longint unsigned sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx + dy * dy);
  endfunction

  // Ray toward +x; edge runs from (x2,y2) to (x,y), click at the origin.
  function automatic int half_cross(longint x2, longint y2, longint x, longint y);
    int     s;
    longint a, b;
    if (y == 0) begin
      if (x == 0) return ON_EDGE;
      if (x > 0) begin
        if (y2 == 0) return (x2 > 0) ? 0 : ON_EDGE;
        return (y2 < 0) ? 1 : -1;
      end
      if (y2 == 0) return (x2 < 0) ? 0 : ON_EDGE;
      return 0;
    end
    s = (y > 0) ? 1 : -1;
    if (y2 == 0) return (x2 < 0) ? 0 : s;
    if ((y > 0) == (y2 > 0)) return 0;
    if (x >= 0 && x2 > 0) return 2 * s;
    if (x < 0 && x2 <= 0) return 0;
    a = y2 * x;
    b = x2 * y;
    if (a == b) return ON_EDGE;
    return ((s > 0) == (a > b)) ? 0 : 2 * s;
  endfunction

  task automatic poly_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    int c;
    c = half_cross(longint'(ax) - longint'(click_x), longint'(ay) - longint'(click_y),
                   longint'(bx) - longint'(click_x), longint'(by) - longint'(click_y));
    if (c == ON_EDGE) on_edge = 1'b1;
    else cross_total += c;
  endtask

  task automatic apply_coord(coord_item_t it);
    longint unsigned d;
    logic            hit, status;
    region_result_t  res;
    hit = 1'b0;
    status = 1'b0;
    if (it.op > OP_BEGIN) return;
    if (it.op == OP_BEGIN) begin
      near_seen = 1'b0;
      near_dist = 0;
      near_region = '0;
      vtx_count = 0;
      cross_total = 0;
      on_edge = 1'b0;
      return;
    end
    if (vtx_count != 0 && it.op != open_op) vtx_count = 0;
    if (vtx_count == 0) begin
      open_op = it.op;
      cross_total = 0;
      on_edge = 1'b0;
    end
    case (it.op)
      OP_RECT, OP_CIRCLE: begin
        if (vtx_count == 0) begin
          first_x = it.x;
          first_y = it.y;
          vtx_count = 1;
        end else if (vtx_count == 1) begin
          prev_x = it.x;
          prev_y = it.y;
          vtx_count = 2;
        end
        if (it.last) begin
          if (vtx_count < 2) begin
            status = 1'b1;
          end else if (it.op == OP_RECT) begin
            hit = first_x <= click_x && prev_x >= click_x &&
                  first_y <= click_y && prev_y >= click_y;
          end else begin
            hit = sq_dist(first_x, first_y, click_x, click_y) <=
                  sq_dist(first_x, first_y, prev_x, prev_y);
          end
        end
      end
      OP_POLY: begin
        if (vtx_count == 0) begin
          first_x = it.x;
          first_y = it.y;
          prev_x = it.x;
          prev_y = it.y;
          if (it.x == click_x && it.y == click_y) on_edge = 1'b1;
          vtx_count = 1;
        end else if (vtx_count < MAX_VTX) begin
          poly_edge(prev_x, prev_y, it.x, it.y);
          prev_x = it.x;
          prev_y = it.y;
          vtx_count++;
        end
        if (it.last) begin
          poly_edge(prev_x, prev_y, first_x, first_y);
          hit = on_edge || cross_total != 0;
        end
      end
      default: begin
        d = sq_dist(it.x, it.y, click_x, click_y);
        if (!near_seen || d < near_dist) begin
          near_dist = d;
          near_region = it.rid;
          near_seen = 1'b1;
        end
        vtx_count = 1;
      end
    endcase
    if (!it.last) return;
    vtx_count = 0;
    res.region = it.rid;
    res.kind = kind_e'(it.op[1:0]);
    res.hit = hit;
    res.status = status;
    res.nvalid = near_seen;
    res.nregion = near_region;
    res.ndist = near_dist[32:0];
    due_results.push_back(res);
  endtask

  task automatic check_field(string name, logic [32:0] want, logic [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // monitor, predictor and watchdog
  bit             in_fire = 1'b0;
  int             quiet_cycles = 0;
  coord_item_t    seen_item;
  region_result_t got_res, want_res;

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.op = s_axis_tuser;
        seen_item.rid = s_axis_tdata[7:0];
        seen_item.x = s_axis_tdata[23:8];
        seen_item.y = s_axis_tdata[39:24];
        seen_item.last = s_axis_tlast;
        apply_coord(seen_item);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.region = m_axis_tdata[7:0];
        got_res.hit = m_axis_tdata[8];
        got_res.status = m_axis_tdata[9];
        got_res.nvalid = m_axis_tdata[10];
        got_res.nregion = m_axis_tdata[18:11];
        got_res.ndist = m_axis_tdata[51:19];
        got_res.kind = kind_e'(m_axis_tuser);
        if (due_results.size() == 0) begin
          $error("unexpected result item for region %0d", got_res.region);
          fails++;
        end else begin
          want_res = due_results.pop_front();
          check_field("out_region", 33'(want_res.region), 33'(got_res.region));
          check_field("region_kind", 33'(want_res.kind), 33'(got_res.kind));
          check_field("hit", 33'(want_res.hit), 33'(got_res.hit));
          check_field("status", 33'(want_res.status), 33'(got_res.status));
          check_field("nearest_valid", 33'(want_res.nvalid), 33'(got_res.nvalid));
          check_field("nearest_region", 33'(want_res.nregion), 33'(got_res.nregion));
          check_field("nearest_dist", want_res.ndist, got_res.ndist);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // sender: bursts with random gaps
  int          burst_left = 0;
  int          gap_left = 0;
  coord_item_t next_item;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0 || coord_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        next_item = coord_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {next_item.y, next_item.x, next_item.rid};
        s_axis_tuser <= next_item.op;
        s_axis_tlast <= next_item.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern by mode, plus one long hold-off
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  logic [15:0] rx_tick = '0;

  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 16'd1;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_tick[8:7])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= rx_tick[2];
      endcase
    end
  end

  task automatic add_coord(logic [2:0] op, logic [7:0] rid, coord_t x, coord_t y, logic last);
    coord_item_t it;
    it.op = op;
    it.rid = rid;
    it.x = x;
    it.y = y;
    it.last = last;
    coord_items.push_back(it);
  endtask

  function automatic coord_t pick_coord(int center, int spread);
    int v;
    if ($urandom_range(0, 9) < 3) return coord_t'($urandom);
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic push_region(op_e op, int n, bit closed);
    logic [7:0] rid;
    coord_t     cx, cy, px, py;
    rid = 8'($urandom_range(0, 255));
    cx = pick_coord(int'(click_x), 20);
    cy = pick_coord(int'(click_y), 20);
    for (int k = 0; k < n; k++) begin
      case (op)
        OP_RECT: begin
          px = pick_coord(int'(click_x) + ((k == 0) ? -4 : 4), 5);
          py = pick_coord(int'(click_y) + ((k == 0) ? -4 : 4), 5);
        end
        OP_CIRCLE: begin
          px = (k == 0) ? cx : pick_coord(int'(cx), 20);
          py = (k == 0) ? cy : pick_coord(int'(cy), 20);
        end
        OP_POLY: begin
          px = pick_coord(int'(click_x), 3);
          py = pick_coord(int'(click_y), 3);
        end
        default: begin
          px = pick_coord(int'(click_x), 60);
          py = pick_coord(int'(click_y), 60);
        end
      endcase
      add_coord(op, rid, px, py, closed && (k == n - 1));
    end
  endtask

  task automatic random_regions(int budget);
    int done_cnt, r, n;
    done_cnt = 0;
    while (done_cnt < budget) begin
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? 1 : 3) : 2;
      if (r < 20) begin
        push_region(OP_RECT, n, 1'b1);
      end else if (r < 40) begin
        push_region(OP_CIRCLE, n, 1'b1);
      end else if (r < 70) begin
        n = $urandom_range(1, 8);
        push_region(OP_POLY, n, 1'b1);
      end else if (r < 85) begin
        n = $urandom_range(1, 4);
        push_region(OP_POINT, n, 1'b1);
      end else if (r < 89) begin
        n = 1;
        add_coord(OP_BEGIN, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (r < 93) begin
        n = 1;
        add_coord(3'($urandom_range(OP_BEGIN + 1, OP_LAST_CODE)), 8'($urandom),
                  16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        n = $urandom_range(1, 3);
        push_region(op_e'($urandom_range(OP_RECT, OP_POINT)), n, 1'b0);
      end
      done_cnt += n;
    end
  endtask

  task automatic set_click(coord_t x, coord_t y);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_CLICK_X;
    cfg_wdata_i <= x;
    @(negedge clk_i);
    cfg_idx_i <= REG_CLICK_Y;
    cfg_wdata_i <= y;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    click_x = x;
    click_y = y;
  endtask

  task automatic drain();
    while (coord_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] rid;
    coord_t     ax, ay;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_click(16'd100, 16'd200);
    add_coord(OP_RECT, 8'd1, 16'd100, 16'd200, 1'b1);       // one corner only
    add_coord(OP_RECT, 8'd2, 16'd100, 16'd200, 1'b0);       // degenerate box on click
    add_coord(OP_RECT, 8'd2, 16'd100, 16'd200, 1'b1);
    add_coord(OP_RECT, 8'd255, 16'd0, 16'd0, 1'b0);         // extra corner ignored
    add_coord(OP_RECT, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    add_coord(OP_RECT, 8'd255, 16'd5, 16'd5, 1'b1);
    add_coord(OP_CIRCLE, 8'd3, 16'd90, 16'd200, 1'b1);      // center only
    add_coord(OP_CIRCLE, 8'd4, 16'd97, 16'd196, 1'b0);      // click on the rim
    add_coord(OP_CIRCLE, 8'd4, 16'd100, 16'd200, 1'b1);
    add_coord(OP_POLY, 8'd5, 16'd100, 16'd200, 1'b1);       // lone vertex on click
    add_coord(OP_POLY, 8'd6, 16'd90, 16'd190, 1'b0);        // triangle around click
    add_coord(OP_POLY, 8'd6, 16'd110, 16'd190, 1'b0);
    add_coord(OP_POLY, 8'd6, 16'd100, 16'd210, 1'b1);
    add_coord(OP_POLY, 8'd7, 16'd90, 16'd200, 1'b0);        // click on first edge
    add_coord(OP_POLY, 8'd7, 16'd110, 16'd200, 1'b0);
    add_coord(OP_POLY, 8'd7, 16'd100, 16'd220, 1'b1);
    add_coord(OP_POINT, 8'd8, 16'd0, 16'd0, 1'b0);
    add_coord(OP_POINT, 8'd9, 16'hFFFF, 16'hFFFF, 1'b1);
    add_coord(OP_RECT, 8'd10, 16'd1, 16'd1, 1'b0);          // dropped by kind change
    add_coord(OP_CIRCLE, 8'd11, 16'd100, 16'd200, 1'b0);
    add_coord(OP_CIRCLE, 8'd11, 16'd101, 16'd200, 1'b1);
    add_coord(OP_BEGIN, 8'd0, 16'd0, 16'd0, 1'b0);
    for (int k = OP_BEGIN + 1; k <= OP_LAST_CODE; k++)
      add_coord(3'(k), 8'hAA, 16'h5555, 16'hAAAA, 1'b1);
    add_coord(OP_POINT, 8'd12, 16'd100, 16'd201, 1'b1);
    drain();

    set_click(16'd0, 16'd0);
    random_regions(20);
    drain();
    set_click(16'hFFFF, 16'hFFFF);
    random_regions(20);
    drain();
    set_click(16'd0, 16'hFFFF);
    random_regions(20);
    hold_req = 1'b1;
    drain();
    set_click(16'($urandom), 16'($urandom));
    random_regions(20);
    drain();
    set_click(16'($urandom_range(0, 255)), 16'($urandom));
    random_regions(20);
    drain();

    // polygon longer than the vertex limit: the tail past it must not count
    set_click(16'($urandom), 16'($urandom));
    rid = 8'($urandom);
    ax = 16'($urandom);
    ay = 16'($urandom);
    add_coord(OP_BEGIN, rid, ax, ay, 1'b0);
    for (int k = 0; k < MAX_VTX; k++) add_coord(OP_POLY, rid, ax, ay, 1'b0);
    for (int k = 0; k < 6; k++)
      add_coord(OP_POLY, rid, pick_coord(int'(click_x), 3000), pick_coord(int'(click_y), 3000),
                k == 5);
    drain();

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
